FILE: hdl/bsm_pkg.sv
// Shared constants and types for the bounding sphere merge block.
// No dependencies; compiled first.
package bsm_pkg;

  localparam int COORD_W         = 32;
  localparam int RAD_W           = 31;
  localparam int SQ_W            = 64;
  localparam int ROOT_W          = 32;
  localparam int DEF_MAX_SPHERES = 256;

  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } bsm_stat_t;

endpackage

FILE: hdl/bsm_if.sv
// Valid/ready channel interfaces for sphere records and merge results.
// Depends on bsm_pkg for field widths.
interface bsm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsm_pkg::COORD_W-1:0] center_x;
  logic signed [bsm_pkg::COORD_W-1:0] center_y;
  logic signed [bsm_pkg::COORD_W-1:0] center_z;
  logic [bsm_pkg::RAD_W-1:0]          radius;
  logic                              renderable;
  logic                              last;

  modport source (output valid, center_x, center_y, center_z, radius, renderable, last,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius, renderable, last,
                  output ready);
endinterface

interface bsm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsm_pkg::COORD_W-1:0] mean_x;
  logic signed [bsm_pkg::COORD_W-1:0] mean_y;
  logic signed [bsm_pkg::COORD_W-1:0] mean_z;
  logic [bsm_pkg::RAD_W-1:0]          enclosing_radius;
  logic                              empty_res;
  logic                              dropped;

  modport source (output valid, mean_x, mean_y, mean_z, enclosing_radius, empty_res,
                  dropped, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, enclosing_radius, empty_res,
                  dropped, output ready);
endinterface

FILE: hdl/bsm_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating to zero.
// Depends on bsm_pkg.
module bsm_div #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [SUM_W-1:0]      dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic [bsm_pkg::COORD_W-1:0]  quot,
  output bsm_pkg::bsm_stat_t           stat
);
  import bsm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    rem_s;
  logic [CNT_W:0]    rem_d;
  logic              ge;

  assign rem_s = {rem_r, quo_r[SUM_W-1]};
  assign ge    = rem_s >= {1'b0, dvs_r};
  assign rem_d = ge ? rem_s - {1'b0, dvs_r} : rem_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? -dividend : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_d[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign quot      = neg_r ? -quo_r[COORD_W-1:0] : quo_r[COORD_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/bsm_sqrt.sv
// Iterative integer square root, one root bit per cycle (floor of sqrt of 64-bit value).
// Depends on bsm_pkg.
module bsm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bsm_pkg::SQ_W-1:0]   op,
  output logic [bsm_pkg::ROOT_W-1:0] root,
  output bsm_pkg::bsm_stat_t         stat
);
  import bsm_pkg::*;

  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   v_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_s;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign rem_s = {rem_r[REM_W-3:0], v_r[SQ_W-1:SQ_W-2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(ROOT_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= op;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? rem_s - trial : rem_s;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/bounding_sphere_merge_top.sv
// Bounding sphere merge: sphere store, sequencer, shared multiplier, divider and root units.
// Depends on bsm_pkg, bsm_if, bsm_div, bsm_sqrt.
//
// Usage: sphere records arrive on in_ch, one transaction per cycle while in_ch.ready is high.
// Renderable records are stored (up to MAX_SPHERES) and their centers summed. A record with
// last set closes the set: ready drops and the block computes the mean center (three serial
// divisions, SUM_W = 32+clog2(MAX_SPHERES+1)) and then walks the stored spheres one at a time,
// each through the 32-step square root unit. An empty set skips the divisions and the walk
// and raises out_ch.valid by way of S_FIN, where the empty_res flag is set.
// The result is held on out_ch until taken; a stalled receiver simply keeps the block busy
// and in_ch.ready low. After the result transaction the set state is cleared and ready rises.
// Reset (rst_n low, synchronous) clears the count, sums and flags; store contents are not
// cleared, as only entries written in the current set are read.
module bounding_sphere_merge_top #(
  parameter int MAX_SPHERES = bsm_pkg::DEF_MAX_SPHERES
) (
  input logic     clk,
  input logic     rst_n,
  bsm_in_if.sink  in_ch,
  bsm_out_if.source out_ch
);
  import bsm_pkg::*;

  localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CW    = $clog2(MAX_SPHERES + 1);
  localparam int SUM_W = COORD_W + CW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVS = 4'd1;
  localparam logic [3:0] S_DIVW = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_SQS  = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [COORD_W-1:0] mem_x [MAX_SPHERES];
  logic [COORD_W-1:0] mem_y [MAX_SPHERES];
  logic [COORD_W-1:0] mem_z [MAX_SPHERES];
  logic [RAD_W-1:0]   mem_r [MAX_SPHERES];

  logic [3:0]               state_r;
  logic [CW-1:0]            cnt_r;
  logic                     ovf_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r, sum_z_r;
  logic [1:0]               axis_r;
  logic [COORD_W-1:0]       mean_x_r, mean_y_r, mean_z_r;
  logic [CW-1:0]            idx_r;
  logic [COORD_W-1:0]       rd_x_r, rd_y_r, rd_z_r;
  logic [RAD_W-1:0]         rd_r_r;
  logic [COORD_W-1:0]       ax_r, ay_r, az_r;
  logic                     far_r;
  logic [1:0]               mcnt_r;
  logic [SQ_W-1:0]          prod_r;
  logic [SQ_W-1:0]          sq_r;
  logic [RAD_W-1:0]         best_r;

  logic [COORD_W-1:0]       o_mx_r, o_my_r, o_mz_r;
  logic [RAD_W-1:0]         o_rad_r;
  logic                     o_empty_r, o_drop_r;

  logic                     acc;
  logic                     store_ok;
  logic                     div_start, sq_start;
  logic signed [SUM_W-1:0]  div_dividend;
  logic [COORD_W-1:0]       div_q;
  bsm_stat_t                div_stat, sq_stat;
  logic [ROOT_W-1:0]        root;
  logic [COORD_W:0]         dx, dy, dz, adx, ady, adz;
  logic [COORD_W-1:0]       msel;
  logic [ROOT_W:0]          term;
  logic [RAD_W-1:0]         term_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign store_ok    = in_ch.renderable && (cnt_r < CW'(MAX_SPHERES));

  always_ff @(posedge clk) begin
    if (acc && store_ok) begin
      mem_x[cnt_r[AW-1:0]] <= in_ch.center_x;
      mem_y[cnt_r[AW-1:0]] <= in_ch.center_y;
      mem_z[cnt_r[AW-1:0]] <= in_ch.center_z;
      mem_r[cnt_r[AW-1:0]] <= in_ch.radius;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[idx_r[AW-1:0]];
    rd_y_r <= mem_y[idx_r[AW-1:0]];
    rd_z_r <= mem_z[idx_r[AW-1:0]];
    rd_r_r <= mem_r[idx_r[AW-1:0]];
  end

  always_comb begin
    case (axis_r)
      2'd0:    div_dividend = sum_x_r;
      2'd1:    div_dividend = sum_y_r;
      default: div_dividend = sum_z_r;
    endcase
  end
  assign div_start = (state_r == S_DIVS);
  assign sq_start  = (state_r == S_SQS);

  bsm_div #(.SUM_W(SUM_W), .CNT_W(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .quot     (div_q),
    .stat     (div_stat)
  );

  bsm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .op    (sq_r),
    .root  (root),
    .stat  (sq_stat)
  );

  assign dx  = {rd_x_r[COORD_W-1], rd_x_r} - {mean_x_r[COORD_W-1], mean_x_r};
  assign dy  = {rd_y_r[COORD_W-1], rd_y_r} - {mean_y_r[COORD_W-1], mean_y_r};
  assign dz  = {rd_z_r[COORD_W-1], rd_z_r} - {mean_z_r[COORD_W-1], mean_z_r};
  assign adx = dx[COORD_W] ? -dx : dx;
  assign ady = dy[COORD_W] ? -dy : dy;
  assign adz = dz[COORD_W] ? -dz : dz;

  always_comb begin
    case (mcnt_r)
      2'd0:    msel = ax_r;
      2'd1:    msel = ay_r;
      default: msel = az_r;
    endcase
  end

  assign term     = {1'b0, root} + (ROOT_W + 1)'(rd_r_r);
  assign term_sat = (far_r || term > (ROOT_W + 1)'(RAD_MAX)) ? RAD_MAX : term[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      best_r  <= '0;
      axis_r  <= '0;
      idx_r   <= '0;
      mcnt_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (store_ok) begin
              sum_x_r <= sum_x_r + SUM_W'(in_ch.center_x);
              sum_y_r <= sum_y_r + SUM_W'(in_ch.center_y);
              sum_z_r <= sum_z_r + SUM_W'(in_ch.center_z);
              cnt_r   <= cnt_r + 1'b1;
            end else if (in_ch.renderable) begin
              ovf_r <= 1'b1;
            end
            if (in_ch.last) begin
              axis_r <= '0;
              if (store_ok || cnt_r != '0) begin
                state_r <= S_DIVS;
              end else begin
                state_r <= S_FIN;
              end
            end
          end
        end
        S_DIVS: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_stat.done) begin
            case (axis_r)
              2'd0:    mean_x_r <= div_q;
              2'd1:    mean_y_r <= div_q;
              default: mean_z_r <= div_q;
            endcase
            if (axis_r == 2'd2) begin
              idx_r   <= '0;
              state_r <= S_RD;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_DIVS;
            end
          end
        end
        S_RD: state_r <= S_DIFF;
        S_DIFF: begin
          ax_r    <= adx[COORD_W-1:0];
          ay_r    <= ady[COORD_W-1:0];
          az_r    <= adz[COORD_W-1:0];
          far_r   <= adx[COORD_W] | adx[COORD_W-1] | ady[COORD_W] | ady[COORD_W-1] |
                     adz[COORD_W] | adz[COORD_W-1];
          mcnt_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mcnt_r != 2'd3) begin
            prod_r <= msel * msel;
          end
          if (mcnt_r == 2'd0) begin
            sq_r <= '0;
          end else begin
            sq_r <= sq_r + prod_r;
          end
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 2'd3) begin
            state_r <= S_SQS;
          end
        end
        S_SQS: state_r <= S_SQW;
        S_SQW: begin
          if (sq_stat.done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (term_sat > best_r) begin
            best_r <= term_sat;
          end
          if (idx_r == cnt_r - 1'b1) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          o_empty_r <= (cnt_r == '0);
          o_drop_r  <= ovf_r;
          o_rad_r   <= best_r;
          o_mx_r    <= (cnt_r == '0) ? '0 : mean_x_r;
          o_my_r    <= (cnt_r == '0) ? '0 : mean_y_r;
          o_mz_r    <= (cnt_r == '0) ? '0 : mean_z_r;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            cnt_r   <= '0;
            ovf_r   <= 1'b0;
            sum_x_r <= '0;
            sum_y_r <= '0;
            sum_z_r <= '0;
            best_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = (state_r == S_OUT);
  assign out_ch.mean_x           = o_mx_r;
  assign out_ch.mean_y           = o_my_r;
  assign out_ch.mean_z           = o_mz_r;
  assign out_ch.enclosing_radius = o_rad_r;
  assign out_ch.empty_res        = o_empty_r;
  assign out_ch.dropped          = o_drop_r;

endmodule

FILE: test/bsm_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side handshake helpers are not needed; this file holds no interfaces of its own.
// The channel interfaces come from hdl/bsm_if.sv; depends on bsm_pkg.
package bsm_tb_pkg;
  import bsm_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          rad;
    logic                      rend;
    logic                      lst;
  } sphere_t;

  typedef struct {
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] mz;
    logic [RAD_W-1:0]          rad;
    logic                      empty;
    logic                      drop;
  } merge_t;
endpackage

FILE: test/bounding_sphere_merge_top_test.sv
`timescale 1ns / 1ps
// Testbench for bounding_sphere_merge_top: directed and random sphere sets,
// results checked against an in-bench enclosing sphere predictor.
// Depends on bsm_pkg, bsm_if, bsm_tb_pkg and the block's RTL.
module bounding_sphere_merge_top_test;
  import bsm_pkg::*;
  import bsm_tb_pkg::*;

  localparam int CAP = DEF_MAX_SPHERES;

  logic clk;
  logic rst_n;
  bsm_in_if  in_ch ();
  bsm_out_if out_ch ();

  bounding_sphere_merge_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic signed [COORD_W-1:0] held_x [CAP];
  logic signed [COORD_W-1:0] held_y [CAP];
  logic signed [COORD_W-1:0] held_z [CAP];
  logic [RAD_W-1:0]          held_r [CAP];
  longint sx, sy, sz;
  int     held_n;
  bit     over;

  merge_t expected_q[$];
  int     errors;
  int     results_seen;
  int     sets_sent;
  int     stall_long;
  bit     drain_done;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs_off(longint a, longint b);
    longint d;
    d = a - b;
    return d < 0 ? -d : d;
  endfunction

  function automatic void merge_predict(sphere_t s);
    merge_t r;
    longint mx, my, mz;
    longint unsigned ax, ay, az, term, best;
    if (s.rend) begin
      if (held_n < CAP) begin
        held_x[held_n] = s.cx;
        held_y[held_n] = s.cy;
        held_z[held_n] = s.cz;
        held_r[held_n] = s.rad;
        sx += s.cx;
        sy += s.cy;
        sz += s.cz;
        held_n++;
      end else begin
        over = 1;
      end
    end
    if (!s.lst) return;
    mx = 0; my = 0; mz = 0; best = 0;
    if (held_n != 0) begin
      mx = sx / held_n;
      my = sy / held_n;
      mz = sz / held_n;
      for (int i = 0; i < held_n; i++) begin
        ax = abs_off(held_x[i], mx);
        ay = abs_off(held_y[i], my);
        az = abs_off(held_z[i], mz);
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000) begin
          term = RAD_MAX;
        end else begin
          term = int_sqrt(ax * ax + ay * ay + az * az) + held_r[i];
          if (term > RAD_MAX) term = RAD_MAX;
        end
        if (term > best) best = term;
      end
    end
    r.mx = mx[31:0];
    r.my = my[31:0];
    r.mz = mz[31:0];
    r.rad = best[30:0];
    r.empty = (held_n == 0);
    r.drop = over;
    expected_q = {expected_q, r};
    sx = 0; sy = 0; sz = 0; held_n = 0; over = 0;
  endfunction

  task automatic send_sphere(sphere_t s);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.center_x   <= s.cx;
    in_ch.center_y   <= s.cy;
    in_ch.center_z   <= s.cz;
    in_ch.radius     <= s.rad;
    in_ch.renderable <= s.rend;
    in_ch.last       <= s.lst;
    do @(posedge clk); while (!in_ch.ready);
    merge_predict(s);
    if (s.lst) sets_sent++;
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int w;
    merge_t e;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      w = $urandom_range(0, 4);
      if (stall_long > 0 || w != 0) out_ch.ready <= 1'b0;
      if (stall_long > 0) begin
        repeat (stall_long) @(posedge clk);
        stall_long = 0;
      end
      repeat (w) @(posedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result mean %0d %0d %0d radius %0d", $time,
                 out_ch.mean_x, out_ch.mean_y, out_ch.mean_z, out_ch.enclosing_radius);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.mean_x !== e.mx) begin
          $display("%0t: mean_x expected %0d actual %0d", $time, e.mx, out_ch.mean_x);
          errors++;
        end
        if (out_ch.mean_y !== e.my) begin
          $display("%0t: mean_y expected %0d actual %0d", $time, e.my, out_ch.mean_y);
          errors++;
        end
        if (out_ch.mean_z !== e.mz) begin
          $display("%0t: mean_z expected %0d actual %0d", $time, e.mz, out_ch.mean_z);
          errors++;
        end
        if (out_ch.enclosing_radius !== e.rad) begin
          $display("%0t: enclosing_radius expected %0d actual %0d", $time, e.rad,
                   out_ch.enclosing_radius);
          errors++;
        end
        if (out_ch.empty_res !== e.empty) begin
          $display("%0t: empty_res expected %0b actual %0b", $time, e.empty,
                   out_ch.empty_res);
          errors++;
        end
        if (out_ch.dropped !== e.drop) begin
          $display("%0t: dropped expected %0b actual %0b", $time, e.drop, out_ch.dropped);
          errors++;
        end
      end
    end
  end

  function automatic sphere_t mk(int cx, int cy, int cz, int unsigned r, bit rend, bit lst);
    sphere_t s;
    s.cx = cx; s.cy = cy; s.cz = cz; s.rad = r[30:0]; s.rend = rend; s.lst = lst;
    return s;
  endfunction

  function automatic sphere_t rand_sphere(bit lst, int span);
    sphere_t s;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      s.cx = $urandom; s.cy = $urandom; s.cz = $urandom; s.rad = RAD_W'($urandom);
    end else begin
      s.cx = $signed($urandom_range(0, 2 * span)) - span;
      s.cy = $signed($urandom_range(0, 2 * span)) - span;
      s.cz = $signed($urandom_range(0, 2 * span)) - span;
      s.rad = RAD_W'($urandom_range(0, span));
    end
    s.rend = ($urandom_range(0, 7) != 0);
    s.lst = lst;
    return s;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    send_sphere(mk(0, 0, 0, 0, 0, 1));                                   // empty set
    send_sphere(mk(32'sh7fffffff, 32'sh80000000, 0, 32'h7fffffff, 1, 1));
    send_sphere(mk(65536, 65536, 65536, 100, 1, 0));                     // sphere at mean
    send_sphere(mk(65536, 65536, 65536, 7, 1, 1));
    send_sphere(mk(32'sh7fffffff, 0, 0, 5, 1, 0));                       // far sphere
    send_sphere(mk(32'sh80000000, 0, 0, 5, 1, 1));
    send_sphere(mk(-3, -3, -3, 0, 1, 0));                                // truncation toward zero
    send_sphere(mk(0, 0, 0, 1, 1, 0));
    send_sphere(mk(3, 3, 4, 2, 0, 0));                                   // skipped sphere
    send_sphere(mk(1, 2, -1, 2, 1, 1));
    send_sphere(mk(3, 4, 0, 0, 1, 0));                                   // exact square root
    send_sphere(mk(-3, -4, 0, 32'h7ffffff0, 1, 1));
    send_sphere(mk(-1, -1, -1, 32'h55555555, 1, 0));
    send_sphere(mk(32'sh55555555, 32'shaaaaaaaa, 32'sh7fffffff, 32'h2aaaaaaa, 0, 1));
    wait_drained();
  endtask

  task automatic test_store_full();
    // one set past capacity, then a set exactly at capacity
    for (int i = 0; i < CAP + 3; i++)
      send_sphere(mk($signed($urandom_range(0, 1 << 20)) - (1 << 19), i, -i, i, 1,
                     i == CAP + 2));
    for (int i = 0; i < CAP; i++) send_sphere(mk(i << 10, -i, 7, 3, 1, i == CAP - 1));
    wait_drained();
  endtask

  task automatic test_backpressure();
    stall_long = 2000;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 4; i++) send_sphere(rand_sphere(i == 3, 1 << 20));
    wait_drained();
  endtask

  task automatic test_random(int items);
    int n, sz, span;
    n = 0;
    while (n < items) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      span = ($urandom_range(0, 3) == 0) ? 32'h7fffffff : (1 << $urandom_range(4, 28));
      for (int i = 0; i < sz; i++) send_sphere(rand_sphere(i == sz - 1, span));
      n += sz;
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    errors = 0; results_seen = 0; sets_sent = 0; stall_long = 0;
    sx = 0; sy = 0; sz = 0; held_n = 0; over = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.center_z = '0;
    in_ch.radius = '0; in_ch.renderable = 1'b0; in_ch.last = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(410);
    test_store_full();
    wait_drained();
    $display("Ran %0d sphere sets, %0d merge results checked, including empty, far,",
             sets_sent, results_seen);
    $display("capacity overflow and long output stall cases.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
